### rtl/gata_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// gata_pkg
// Shared types and constants of the greedy agent task assignment unit.
// -----------------------------------------------------------------------------
package gata_pkg;

  // Most picks made in one assignment run.
  localparam int MAX_RESULTS = 8;
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

  localparam int COST_W  = 40;
  localparam int ORDER_W = 16;
  localparam int DIST_W  = 16;
  localparam int TL_W    = 12;
  localparam int SQ_W    = 2 * TL_W;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_DIST_OFFSET = 2'd0,
    REG_AGENTS      = 2'd1,
    REG_TASKS       = 2'd2
  } reg_idx_e;

  // Operation of the shared multiplier.
  typedef enum logic [1:0] {
    ALU_HOLD,
    ALU_SQUARE,
    ALU_SCALE
  } alu_op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SQUARE,
    ST_SCALE,
    ST_UPDATE,
    ST_NEXT,
    ST_SCAN,
    ST_PICK,
    ST_EMIT_MID,
    ST_EMIT_LAST
  } state_e;

  // One agent-task cell of the cost table.
  typedef struct packed {
    logic               valid;
    logic [COST_W-1:0]  cost;
    logic [ORDER_W-1:0] order;
  } cell_t;

endpackage
`default_nettype wire

### rtl/gata_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// gata_alu
// Shared multiplier with its product register, and the shared cost comparator.
// -----------------------------------------------------------------------------
module gata_alu (
  input  wire logic                         clk_i,
  input  wire gata_pkg::alu_op_e            op_i,
  input  wire logic [gata_pkg::TL_W-1:0]    time_left_i,
  input  wire logic [gata_pkg::DIST_W-1:0]  dist_term_i,
  input  wire logic [gata_pkg::COST_W-1:0]  cmp_a_i,
  input  wire logic [gata_pkg::COST_W-1:0]  cmp_b_i,
  output logic      [gata_pkg::COST_W-1:0]  prod_o,
  output logic                              lt_o
);

  logic [gata_pkg::DIST_W-1:0] mul_a;
  logic [gata_pkg::SQ_W-1:0]   mul_b;
  logic [gata_pkg::COST_W-1:0] prod_d, prod_q;

  // The square of time left is taken first, then scaled by the distance term.
  always_comb begin
    if (op_i == gata_pkg::ALU_SQUARE) begin
      mul_a = gata_pkg::DIST_W'(time_left_i);
      mul_b = gata_pkg::SQ_W'(time_left_i);
    end else begin
      mul_a = dist_term_i;
      mul_b = prod_q[gata_pkg::SQ_W-1:0];
    end
    prod_d = gata_pkg::COST_W'(mul_a) * gata_pkg::COST_W'(mul_b);
  end

  always_ff @(posedge clk_i) begin
    if (op_i != gata_pkg::ALU_HOLD) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;
  assign lt_o   = cmp_a_i < cmp_b_i;

endmodule
`default_nettype wire

### rtl/gata_cell_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// gata_cell_mem
// Cost table: one write port and one registered read port, one cell per entry.
// -----------------------------------------------------------------------------
module gata_cell_mem #(
  parameter int AW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            wr_en_i,
  input  wire logic [AW-1:0]   wr_addr_i,
  input  wire gata_pkg::cell_t wr_data_i,
  input  wire logic            rd_en_i,
  input  wire logic [AW-1:0]   rd_addr_i,
  output gata_pkg::cell_t      rd_data_o
);

  localparam int DEPTH = 2 ** AW;

  gata_pkg::cell_t mem [DEPTH];
  gata_pkg::cell_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule
`default_nettype wire

### rtl/greedy_agent_task_assignment_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// greedy_agent_task_assignment_unit
// Keeps the cheapest order per agent-task cell and assigns agents to tasks
// greedily by minimum cost once a batch of observations is complete.
// -----------------------------------------------------------------------------
// An observation beat passes through accept, square, scale and table update,
// because one multiplier computes the cost in two passes and the table cell is
// read through the registered read port before it is rewritten. The beat
// flagged last then runs pick rounds: each round sweeps all in-use cells
// through the read port, one cell a cycle, and may then wait for a result
// beat to be taken; at most eight rounds pick, and a run with fewer picks
// ends with one more round that finds nothing. After the final result a
// clearing pass writes every cell once (MAX_AGENTS * MAX_TASKS cells, 256 at
// the defaults); the same pass runs after reset. Input is not accepted until
// it ends.
// -----------------------------------------------------------------------------
module greedy_agent_task_assignment_unit #(
  parameter int MAX_AGENTS = 8,
  parameter int MAX_TASKS  = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  // Observations.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: agent[2:0], task_req[7:3], order_number[23:8], distance[39:24],
  //        time_left[51:40], zero fill[55:52]
  input  wire logic [55:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,
  // Assignments.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: assigned_agent[2:0], assigned_task[7:3], assigned_order[23:8]
  output logic [23:0]      m_axis_tdata,
  // tuser: found[0]
  output logic             m_axis_tuser,
  output logic             m_axis_tlast
);

  localparam int AGW = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
  localparam int TW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int AW  = AGW + TW;
  localparam int ACW = ($clog2(MAX_AGENTS + 1) > 4) ? $clog2(MAX_AGENTS + 1) : 4;
  localparam int TCW = ($clog2(MAX_TASKS + 1) > 6) ? $clog2(MAX_TASKS + 1) : 6;

  localparam int CW  = gata_pkg::COST_W;
  localparam int OW  = gata_pkg::ORDER_W;
  localparam int NW  = gata_pkg::NRES_W;

  gata_pkg::state_e state_d, state_q;

  logic [15:0] dist_off_q;
  logic [3:0]  agents_q;
  logic [5:0]  tasks_q;

  logic [AGW-1:0] ag_d, ag_q;
  logic [TW-1:0]  tk_d, tk_q;
  logic [OW-1:0]  ord_d, ord_q;
  logic [15:0]    dist_d, dist_q;
  logic [11:0]    tl_d, tl_q;
  logic           last_d, last_q;
  logic           hit_d, hit_q;
  logic [15:0]    dterm_d, dterm_q;

  logic [AGW-1:0] ca_d, ca_q;
  logic [TW-1:0]  ct_d, ct_q;
  logic           iss_d, iss_q;
  logic           pv_d, pv_q;
  logic [AGW-1:0] pa_d, pa_q;
  logic [TW-1:0]  pt_d, pt_q;

  logic           have_d, have_q;
  logic [CW-1:0]  best_d, best_q;
  logic [AGW-1:0] ba_d, ba_q;
  logic [TW-1:0]  bt_d, bt_q;
  logic [OW-1:0]  bo_d, bo_q;

  logic           pend_d, pend_q;
  logic [AGW-1:0] pk_agent_d, pk_agent_q;
  logic [TW-1:0]  pk_task_d, pk_task_q;
  logic [OW-1:0]  pk_order_d, pk_order_q;
  logic [NW-1:0]  nres_d, nres_q;
  logic           stop_d, stop_q;

  logic [MAX_TASKS-1:0]  task_open_d, task_open_q;
  logic [MAX_AGENTS-1:0] agent_taken_d, agent_taken_q;

  logic        out_valid_d, out_valid_q;
  logic [23:0] out_data_d, out_data_q;
  logic        out_found_d, out_found_q;
  logic        out_last_d, out_last_q;

  logic [ACW-1:0] na, lim_a;
  logic [TCW-1:0] nt, lim_t;
  logic           t_wrap, a_wrap;

  gata_pkg::alu_op_e alu_op;
  logic [CW-1:0]     cmp_a, cmp_b, prod;
  logic              lt;

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  gata_pkg::cell_t mem_wdata, mem_rdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_off_q <= 16'd150;
      agents_q   <= 4'd8;
      tasks_q    <= 6'd32;
    end else if (cfg_we_i) begin
      case (gata_pkg::reg_idx_e'(cfg_idx_i))
        gata_pkg::REG_DIST_OFFSET: dist_off_q <= cfg_data_i;
        gata_pkg::REG_AGENTS:      agents_q   <= cfg_data_i[3:0];
        gata_pkg::REG_TASKS:       tasks_q    <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // Counts in use, clamped to the table size.
  assign na = (ACW'(agents_q) > ACW'(MAX_AGENTS)) ? ACW'(MAX_AGENTS) : ACW'(agents_q);
  assign nt = (TCW'(tasks_q) > TCW'(MAX_TASKS)) ? TCW'(MAX_TASKS) : TCW'(tasks_q);

  // The clearing pass sweeps the whole table, the scan only the cells in use.
  assign lim_a  = (state_q == gata_pkg::ST_CLEAR) ? ACW'(MAX_AGENTS) : na;
  assign lim_t  = (state_q == gata_pkg::ST_CLEAR) ? TCW'(MAX_TASKS) : nt;
  assign t_wrap = (TCW'(ct_q) + TCW'(1)) == lim_t;
  assign a_wrap = (ACW'(ca_q) + ACW'(1)) == lim_a;

  gata_alu u_alu (
    .clk_i       (clk_i),
    .op_i        (alu_op),
    .time_left_i (tl_q),
    .dist_term_i (dterm_q),
    .cmp_a_i     (cmp_a),
    .cmp_b_i     (cmp_b),
    .prod_o      (prod),
    .lt_o        (lt)
  );

  gata_cell_mem #(
    .AW (AW)
  ) u_cell_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  always_comb begin
    state_d       = state_q;
    ag_d          = ag_q;
    tk_d          = tk_q;
    ord_d         = ord_q;
    dist_d        = dist_q;
    tl_d          = tl_q;
    last_d        = last_q;
    hit_d         = hit_q;
    dterm_d       = dterm_q;
    ca_d          = ca_q;
    ct_d          = ct_q;
    iss_d         = iss_q;
    pv_d          = 1'b0;
    pa_d          = pa_q;
    pt_d          = pt_q;
    have_d        = have_q;
    best_d        = best_q;
    ba_d          = ba_q;
    bt_d          = bt_q;
    bo_d          = bo_q;
    pend_d        = pend_q;
    pk_agent_d    = pk_agent_q;
    pk_task_d     = pk_task_q;
    pk_order_d    = pk_order_q;
    nres_d        = nres_q;
    stop_d        = stop_q;
    task_open_d   = task_open_q;
    agent_taken_d = agent_taken_q;
    out_valid_d   = out_valid_q;
    out_data_d    = out_data_q;
    out_found_d   = out_found_q;
    out_last_d    = out_last_q;

    s_axis_tready = 1'b0;
    alu_op        = gata_pkg::ALU_HOLD;
    cmp_a         = prod;
    cmp_b         = mem_rdata.cost;
    mem_we        = 1'b0;
    mem_waddr     = {ca_q, ct_q};
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = {ag_q, tk_q};

    case (state_q)
      gata_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (t_wrap) begin
          ct_d = '0;
          ca_d = AGW'(ca_q + AGW'(1));
          if (a_wrap) begin
            ca_d    = '0;
            state_d = gata_pkg::ST_IDLE;
          end
        end else begin
          ct_d = TW'(ct_q + TW'(1));
        end
      end

      gata_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          ag_d    = AGW'(s_axis_tdata[2:0]);
          tk_d    = TW'(s_axis_tdata[7:3]);
          ord_d   = s_axis_tdata[23:8];
          dist_d  = s_axis_tdata[39:24];
          tl_d    = s_axis_tdata[51:40];
          last_d  = s_axis_tlast;
          hit_d   = (ACW'(s_axis_tdata[2:0]) < na) && (TCW'(s_axis_tdata[7:3]) < nt);
          state_d = gata_pkg::ST_SQUARE;
        end
      end

      gata_pkg::ST_SQUARE: begin
        alu_op  = gata_pkg::ALU_SQUARE;
        mem_re  = 1'b1;
        dterm_d = (dist_q > dist_off_q) ? 16'(dist_q - dist_off_q) : 16'd1;
        state_d = gata_pkg::ST_SCALE;
      end

      gata_pkg::ST_SCALE: begin
        alu_op  = gata_pkg::ALU_SCALE;
        state_d = gata_pkg::ST_UPDATE;
      end

      gata_pkg::ST_UPDATE: begin
        // A cell keeps its first order unless a strictly cheaper one arrives.
        if (hit_q) begin
          task_open_d[tk_q] = 1'b1;
          if (!mem_rdata.valid || lt) begin
            mem_we          = 1'b1;
            mem_waddr       = {ag_q, tk_q};
            mem_wdata.valid = 1'b1;
            mem_wdata.cost  = prod;
            mem_wdata.order = ord_q;
          end
        end
        state_d = last_q ? gata_pkg::ST_NEXT : gata_pkg::ST_IDLE;
      end

      gata_pkg::ST_NEXT: begin
        if (stop_q || (nres_q == NW'(gata_pkg::MAX_RESULTS))) begin
          out_valid_d = 1'b1;
          out_found_d = pend_q;
          out_last_d  = 1'b1;
          out_data_d  = pend_q ? {pk_order_q, 5'(pk_task_q), 3'(pk_agent_q)} : 24'd0;
          state_d     = gata_pkg::ST_EMIT_LAST;
        end else begin
          ca_d    = '0;
          ct_d    = '0;
          have_d  = 1'b0;
          iss_d   = (na != '0) && (nt != '0);
          state_d = gata_pkg::ST_SCAN;
        end
      end

      gata_pkg::ST_SCAN: begin
        // Issue one cell read per cycle; judge the cell whose read was issued in the cycle before.
        if (iss_q) begin
          mem_re    = 1'b1;
          mem_raddr = {ca_q, ct_q};
          pv_d      = 1'b1;
          pa_d      = ca_q;
          pt_d      = ct_q;
          if (t_wrap) begin
            ct_d = '0;
            ca_d = AGW'(ca_q + AGW'(1));
            if (a_wrap) begin
              iss_d = 1'b0;
            end
          end else begin
            ct_d = TW'(ct_q + TW'(1));
          end
        end
        cmp_a = mem_rdata.cost;
        cmp_b = best_q;
        if (pv_q && mem_rdata.valid && task_open_q[pt_q] && !agent_taken_q[pa_q] &&
            (!have_q || lt)) begin
          have_d = 1'b1;
          best_d = mem_rdata.cost;
          ba_d   = pa_q;
          bt_d   = pt_q;
          bo_d   = mem_rdata.order;
        end
        if (!iss_q && !pv_q) begin
          state_d = gata_pkg::ST_PICK;
        end
      end

      gata_pkg::ST_PICK: begin
        // A pick is held back one round so that the run's last one can carry tlast.
        if (have_q) begin
          task_open_d[bt_q]   = 1'b0;
          agent_taken_d[ba_q] = 1'b1;
          nres_d              = NW'(nres_q + NW'(1));
          pend_d              = 1'b1;
          pk_agent_d          = ba_q;
          pk_task_d           = bt_q;
          pk_order_d          = bo_q;
          if (pend_q) begin
            out_valid_d = 1'b1;
            out_found_d = 1'b1;
            out_last_d  = 1'b0;
            out_data_d  = {pk_order_q, 5'(pk_task_q), 3'(pk_agent_q)};
            state_d     = gata_pkg::ST_EMIT_MID;
          end else begin
            state_d = gata_pkg::ST_NEXT;
          end
        end else begin
          stop_d  = 1'b1;
          state_d = gata_pkg::ST_NEXT;
        end
      end

      gata_pkg::ST_EMIT_MID: begin
        if (m_axis_tready) begin
          out_valid_d = 1'b0;
          state_d     = gata_pkg::ST_NEXT;
        end
      end

      gata_pkg::ST_EMIT_LAST: begin
        if (m_axis_tready) begin
          out_valid_d   = 1'b0;
          task_open_d   = '0;
          agent_taken_d = '0;
          pend_d        = 1'b0;
          nres_d        = '0;
          stop_d        = 1'b0;
          ca_d          = '0;
          ct_d          = '0;
          state_d       = gata_pkg::ST_CLEAR;
        end
      end

      default: begin
        state_d = gata_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= gata_pkg::ST_CLEAR;
      ca_q          <= '0;
      ct_q          <= '0;
      iss_q         <= 1'b0;
      pv_q          <= 1'b0;
      have_q        <= 1'b0;
      pend_q        <= 1'b0;
      nres_q        <= '0;
      stop_q        <= 1'b0;
      task_open_q   <= '0;
      agent_taken_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      ca_q          <= ca_d;
      ct_q          <= ct_d;
      iss_q         <= iss_d;
      pv_q          <= pv_d;
      have_q        <= have_d;
      pend_q        <= pend_d;
      nres_q        <= nres_d;
      stop_q        <= stop_d;
      task_open_q   <= task_open_d;
      agent_taken_q <= agent_taken_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ag_q       <= ag_d;
    tk_q       <= tk_d;
    ord_q      <= ord_d;
    dist_q     <= dist_d;
    tl_q       <= tl_d;
    last_q     <= last_d;
    hit_q      <= hit_d;
    dterm_q    <= dterm_d;
    pa_q       <= pa_d;
    pt_q       <= pt_d;
    best_q     <= best_d;
    ba_q       <= ba_d;
    bt_q       <= bt_d;
    bo_q       <= bo_d;
    pk_agent_q <= pk_agent_d;
    pk_task_q  <= pk_task_d;
    pk_order_q <= pk_order_d;
    out_data_q <= out_data_d;
    out_found_q <= out_found_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tlast  = out_last_q;

  // Every pick takes exactly one agent until the run is closed.
  a_taken_matches_picks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(agent_taken_q) == int'(nres_q))
    else $error("taken agents differ from the pick count");

  a_pick_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nres_q <= NW'(gata_pkg::MAX_RESULTS))
    else $error("more picks than allowed in one run");

  a_out_only_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == gata_pkg::ST_EMIT_MID || state_q == gata_pkg::ST_EMIT_LAST))
    else $error("result beat shown outside an emit state");

  a_last_beat_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
      (state_q == gata_pkg::ST_CLEAR && task_open_q == '0 && !pend_q))
    else $error("run state not cleared after the final result beat");

endmodule
`default_nettype wire

### bench/tb_greedy_agent_task_assignment_unit.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_greedy_agent_task_assignment_unit
// Streams batches of agent-task observations into the assignment unit and
// checks every assignment beat against an in-bench model of the cost table and
// the greedy pick, under several register settings and handshake patterns.
// -----------------------------------------------------------------------------
module tb_greedy_agent_task_assignment_unit;

  localparam int          AGENT_SLOTS   = 8;
  localparam int          TASK_SLOTS    = 32;
  localparam int          CELL_COUNT    = AGENT_SLOTS * TASK_SLOTS;
  // Covers the table clearing pass that follows every run.
  localparam int          SETTLE_CYCLES = 300;
  localparam int          HOLD_CYCLES   = 3000;
  localparam int unsigned LIMIT_CYCLES  = 1000000;

  typedef struct packed {
    logic [2:0]  agent;
    logic [4:0]  task_idx;
    logic [15:0] order_no;
    logic [15:0] distance;
    logic [11:0] tleft;
    logic        last;
  } obs_t;

  typedef struct packed {
    logic        found;
    logic [2:0]  agent;
    logic [4:0]  task_idx;
    logic [15:0] order_no;
    logic        last_res;
  } assignment_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = gata_pkg::REG_DIST_OFFSET;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // Register copies and cost table of the model.
  logic [15:0]                 cfg_offset = 16'd150;
  logic [3:0]                  cfg_agents = 4'd8;
  logic [5:0]                  cfg_tasks  = 6'd32;
  logic [gata_pkg::COST_W-1:0] cell_cost  [CELL_COUNT];
  logic [15:0]                 cell_order [CELL_COUNT];
  bit                          cell_valid [CELL_COUNT];
  bit                          task_open  [TASK_SLOTS];
  bit                          agent_taken[AGENT_SLOTS];

  assignment_t assign_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned err_count     = 0;

  greedy_agent_task_assignment_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off counted down here once requested.
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------
  function automatic int unsigned agents_active();
    return (cfg_agents > AGENT_SLOTS) ? AGENT_SLOTS : cfg_agents;
  endfunction

  function automatic int unsigned tasks_active();
    return (cfg_tasks > TASK_SLOTS) ? TASK_SLOTS : cfg_tasks;
  endfunction

  function automatic logic [gata_pkg::COST_W-1:0] obs_cost(input logic [15:0] distance,
                                                          input logic [11:0] tleft);
    logic [15:0]               span;
    logic [gata_pkg::SQ_W-1:0] sq;
    span = (distance > cfg_offset) ? distance - cfg_offset : 16'd1;
    sq   = gata_pkg::SQ_W'(tleft) * gata_pkg::SQ_W'(tleft);
    return gata_pkg::COST_W'(span) * gata_pkg::COST_W'(sq);
  endfunction

  task automatic apply_observation(input obs_t o);
    int unsigned                 na;
    int unsigned                 nt;
    int unsigned                 cell_idx;
    int unsigned                 best_a;
    int unsigned                 best_t;
    int unsigned                 picks;
    logic [gata_pkg::COST_W-1:0] c;
    logic [gata_pkg::COST_W-1:0] best;
    bit                          have;
    assignment_t                 res;
    na = agents_active();
    nt = tasks_active();
    if (o.agent < na && o.task_idx < nt) begin
      cell_idx = o.agent * TASK_SLOTS + o.task_idx;
      c        = obs_cost(o.distance, o.tleft);
      // On equal cost the order already stored is kept.
      if (!cell_valid[cell_idx] || cell_cost[cell_idx] > c) begin
        cell_cost[cell_idx]  = c;
        cell_order[cell_idx] = o.order_no;
        cell_valid[cell_idx] = 1'b1;
      end
      task_open[o.task_idx] = 1'b1;
    end
    if (!o.last) return;
    picks = 0;
    while (picks < gata_pkg::MAX_RESULTS) begin
      have   = 1'b0;
      best   = '0;
      best_a = 0;
      best_t = 0;
      // Strict compare in agent-major order gives ties to the first cell.
      for (int unsigned a = 0; a < na; a++) begin
        if (agent_taken[a]) continue;
        for (int unsigned t = 0; t < nt; t++) begin
          cell_idx = a * TASK_SLOTS + t;
          if (task_open[t] && cell_valid[cell_idx] &&
              (!have || cell_cost[cell_idx] < best)) begin
            have   = 1'b1;
            best   = cell_cost[cell_idx];
            best_a = a;
            best_t = t;
          end
        end
      end
      if (!have) break;
      task_open[best_t]   = 1'b0;
      agent_taken[best_a] = 1'b1;
      res.found    = 1'b1;
      res.agent    = 3'(best_a);
      res.task_idx = 5'(best_t);
      res.order_no = cell_order[best_a * TASK_SLOTS + best_t];
      res.last_res = 1'b0;
      assign_q.push_back(res);
      picks++;
    end
    if (picks == 0) begin
      res          = '0;
      res.last_res = 1'b1;
      assign_q.push_back(res);
    end else begin
      res          = assign_q.pop_back();
      res.last_res = 1'b1;
      assign_q.push_back(res);
    end
    for (int unsigned i = 0; i < CELL_COUNT; i++) cell_valid[i] = 1'b0;
    for (int unsigned i = 0; i < TASK_SLOTS; i++) task_open[i] = 1'b0;
    for (int unsigned i = 0; i < AGENT_SLOTS; i++) agent_taken[i] = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Checker
  // ---------------------------------------------------------------------------
  task automatic note_error(input string what, input assignment_t want,
                            input assignment_t got);
    err_count++;
    if (err_count <= 10)
      $display({"%0t: %s: expected found=%0d agent=%0d task=%0d order=%h last=%0d,",
                " got found=%0d agent=%0d task=%0d order=%h last=%0d"},
               $realtime, what, want.found, want.agent, want.task_idx, want.order_no,
               want.last_res, got.found, got.agent, got.task_idx, got.order_no,
               got.last_res);
  endtask

  always @(posedge clk_i) begin
    assignment_t got;
    assignment_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.found    = m_axis_tuser;
      got.agent    = m_axis_tdata[2:0];
      got.task_idx = m_axis_tdata[7:3];
      got.order_no = m_axis_tdata[23:8];
      got.last_res = m_axis_tlast;
      if (assign_q.size() == 0) begin
        note_error("unexpected beat", '0, got);
      end else begin
        want = assign_q.pop_front();
        if (got.found !== want.found || got.agent !== want.agent ||
            got.task_idx !== want.task_idx || got.order_no !== want.order_no ||
            got.last_res !== want.last_res)
          note_error("mismatch", want, got);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic obs_t mk_obs(input logic [2:0] agent, input logic [4:0] task_idx,
                                  input logic [15:0] order_no, input logic [15:0] distance,
                                  input logic [11:0] tleft, input logic last);
    obs_t o;
    o.agent    = agent;
    o.task_idx = task_idx;
    o.order_no = order_no;
    o.distance = distance;
    o.tleft    = tleft;
    o.last     = last;
    return o;
  endfunction

  function automatic obs_t random_obs(input logic last);
    obs_t        o;
    int unsigned na;
    int unsigned nt;
    na = agents_active();
    nt = tasks_active();
    o.agent    = 3'($urandom_range(7));
    o.task_idx = 5'($urandom_range(31));
    // Mostly cells in use; the rest may be any cell, and those outside use are ignored by the block.
    if (na != 0 && nt != 0 && $urandom_range(9) != 0) begin
      o.agent    = 3'($urandom_range(na - 1));
      o.task_idx = 5'($urandom_range(nt - 1));
    end
    o.order_no = 16'($urandom_range(16'hFFFF));
    if ($urandom_range(3) == 0)
      o.distance = 16'(cfg_offset + $urandom_range(2) - 1);
    else
      o.distance = 16'($urandom_range(16'hFFFF));
    o.tleft = ($urandom_range(4) == 0) ? 12'($urandom_range(15)) :
                                         12'($urandom_range(12'hFFF));
    o.last  = last;
    return o;
  endfunction

  // Starts and ends on a falling edge.
  task automatic send_obs(input obs_t o);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, o.tleft, o.distance, o.order_no, o.task_idx, o.agent};
    s_axis_tlast  <= o.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    apply_observation(o);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (assign_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] offset, input logic [3:0] agents,
                            input logic [5:0] tasks);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= gata_pkg::REG_DIST_OFFSET;
    cfg_data_i <= offset;
    @(negedge clk_i);
    cfg_idx_i  <= gata_pkg::REG_AGENTS;
    cfg_data_i <= {12'd0, agents};
    @(negedge clk_i);
    cfg_idx_i  <= gata_pkg::REG_TASKS;
    cfg_data_i <= {10'd0, tasks};
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_offset = offset;
    cfg_agents = agents;
    cfg_tasks  = tasks;
  endtask

  task automatic send_random_batches(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 10);
      for (int unsigned k = 0; k < len; k++) send_obs(random_obs(k == len - 1));
      sent += len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    // Widest cost that fits the table.
    send_obs(mk_obs(3'd7, 5'd31, 16'hFFFF, 16'hFFFF, 12'hFFF, 1'b1));
    // Ties within a cell, ties across cells, clamp at and below the offset.
    send_obs(mk_obs(3'd0, 5'd0, 16'd1, 16'd0, 12'd16, 1'b0));
    send_obs(mk_obs(3'd0, 5'd0, 16'd2, 16'd0, 12'd16, 1'b0));
    send_obs(mk_obs(3'd1, 5'd0, 16'd3, 16'd150, 12'd16, 1'b0));
    send_obs(mk_obs(3'd1, 5'd1, 16'd4, 16'd151, 12'd16, 1'b0));
    send_obs(mk_obs(3'd2, 5'd2, 16'd5, 16'd200, 12'd0, 1'b0));
    send_obs(mk_obs(3'd2, 5'd2, 16'd6, 16'd0, 12'd1, 1'b0));
    send_obs(mk_obs(3'd2, 5'd2, 16'd7, 16'hFFFF, 12'd0, 1'b0));
    send_obs(mk_obs(3'd3, 5'd3, 16'd8, 16'd1000, 12'd100, 1'b0));
    send_obs(mk_obs(3'd3, 5'd3, 16'd9, 16'd300, 12'd100, 1'b1));
    // Every agent wins a task, so the run makes the most picks.
    for (int unsigned a = 0; a < AGENT_SLOTS; a++)
      send_obs(mk_obs(3'(a), 5'(31 - a), 16'(100 + a), 16'($urandom_range(16'hFFFF)),
                      12'($urandom_range(12'hFFF)), 1'b0));
    send_obs(mk_obs(3'd0, 5'd0, 16'd500, 16'd150, 12'd1, 1'b1));
  endtask

  task automatic test_config_extremes();
    wait_idle();
    set_config(16'd0, 4'd1, 6'd1);
    send_obs(mk_obs(3'd0, 5'd0, 16'h1234, 16'd0, 12'd40, 1'b0));
    send_obs(mk_obs(3'd1, 5'd3, 16'h2222, 16'd5, 12'd1, 1'b0));
    send_obs(mk_obs(3'd0, 5'd1, 16'h3333, 16'd5, 12'd1, 1'b0));
    send_obs(mk_obs(3'd0, 5'd0, 16'h4321, 16'd3, 12'd20, 1'b1));
    wait_idle();
    // Every distance clamps to one.
    set_config(16'hFFFF, 4'd8, 6'd32);
    for (int unsigned k = 0; k < 5; k++) send_obs(random_obs(k == 4));
    wait_idle();
    // No agent takes part: only the empty result comes back.
    set_config(16'd0, 4'd0, 6'd32);
    send_obs(mk_obs(3'd0, 5'd0, 16'd77, 16'd10, 12'd10, 1'b1));
    wait_idle();
    // Counts above the table size are clamped.
    set_config(16'd1, 4'd15, 6'd63);
    for (int unsigned k = 0; k < 8; k++) send_obs(random_obs(k == 7));
    wait_idle();
    // A last beat outside the range in use still closes the batch.
    set_config(16'd100, 4'd3, 6'd5);
    send_obs(mk_obs(3'd1, 5'd2, 16'd9, 16'd120, 12'd30, 1'b0));
    send_obs(mk_obs(3'd5, 5'd0, 16'd10, 16'd120, 12'd30, 1'b1));
    wait_idle();
    set_config(16'd100, 4'd3, 6'd5);
    send_obs(mk_obs(3'd0, 5'd9, 16'd11, 16'd120, 12'd30, 1'b1));
  endtask

  task automatic test_backpressure();
    wait_idle();
    set_config(16'd150, 4'd8, 6'd32);
    @(posedge clk_i);
    hold_req++;
    @(negedge clk_i);
    // Results pile up behind the hold-off and input stalls.
    for (int unsigned k = 0; k < 16; k++)
      send_obs(mk_obs(3'(k % 8), 5'(k / 2), 16'($urandom_range(16'hFFFF)),
                      16'($urandom_range(16'hFFFF)), 12'($urandom_range(12'hFFF)),
                      k == 15));
    for (int unsigned k = 0; k < 6; k++) send_obs(random_obs(k == 5));
    wait_idle();
  endtask

  task automatic test_random();
    int unsigned send_pct[4];
    int unsigned recv_pct[4];
    send_pct = '{0, 82, 0, 11};
    recv_pct = '{0, 0, 82, 11};
    for (int unsigned p = 0; p < 4; p++) begin
      wait_idle();
      send_idle_pct = send_pct[p];
      stall_pct     = recv_pct[p];
      set_config($urandom_range(1) ? 16'($urandom_range(400)) : 16'($urandom_range(16'hFFFF)),
                 4'($urandom_range(1, 8)),
                 $urandom_range(1) ? 6'($urandom_range(1, 8)) : 6'($urandom_range(1, 32)));
      send_random_batches(40);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random();
    wait_idle();
    if (assign_q.size() != 0) err_count += assign_q.size();
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
